@@ rtl/ams_pkg.sv @@
// Shared types and constants of the adjacency matrix store.
`timescale 1ns / 1ps

package ams_pkg;

  // Default matrix side and cap on results of one neighbour listing
  localparam int unsigned MaxVertices = 32;
  localparam int unsigned MaxResults  = 32;

  // Field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned VtxW    = 5;
  localparam int unsigned WeightW = 16;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CntW    = $clog2(MaxResults + 1);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDirected = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgActive   = 1'b1;

  // Operation codes; code 3 is a no-op handled by the default arm
  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_LIST   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD2,
    S_LOOK,
    S_LIST,
    S_FIN
  } state_e;

  // One matrix entry: valid bit and weight
  typedef struct packed {
    logic                      present;
    logic signed [WeightW-1:0] weight;
  } entry_t;

  // One result item
  typedef struct packed {
    logic                      status;
    logic                      found;
    logic [VtxW-1:0]           nb;
    logic signed [WeightW-1:0] weight;
    logic                      last;
  } res_t;

endpackage

@@ rtl/ams_ram.sv @@
// Single-port matrix memory with registered read data.
`timescale 1ns / 1ps

module ams_ram import ams_pkg::*; #(
  parameter int unsigned DEPTH = MaxVertices * MaxVertices,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  entry_t        wdata_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/adjacency_matrix_store.sv @@
// Top level of the weighted adjacency matrix store.
//
//  Channel   Direction  Signals                               Contents
//  s_axis    in         tvalid tready tdata[31:0]             request: func, src, dst, weight
//  m_axis    out        tvalid tready tdata[23:0] tuser tlast result: nb, weight; status, found
//  cfg       in         cfg_we_i cfg_idx_i cfg_data_i         0 directed_graph, 1 active_vertices
//
// Add edge writes its entry when the request is taken; the mirrored entry of an undirected
// edge is written from S_ADD2 (one memory write port). Look up reads the memory, then loads
// the result in S_LOOK. A listing reads one row entry per cycle while the result side does
// not stall; the scan holds until the held result can be passed on.
// After reset a clearing pass writes every entry once; no request is taken during it,
// configuration writes are.
`timescale 1ns / 1ps

module adjacency_matrix_store import ams_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVertices
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request: [1:0] func, [6:2] src_vertex, [11:7] dst_vertex, [27:12] edge_weight
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,
  // result: [4:0] neighbor_vertex, [20:5] weight_out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,
  // result flags: [0] status, [1] found
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);

  // Configuration registers
  logic            directed_q;
  logic [CfgW-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q <= 1'b0;
      active_q   <= CfgW'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDirected: directed_q <= cfg_data_i[0];
        CfgActive:   active_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Vertex count in use, capped at the matrix side
  logic [CW-1:0] n_eff;
  assign n_eff = (int'(active_q) > int'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(active_q);

  // Request fields
  logic [FuncW-1:0]          in_func;
  logic [VtxW-1:0]           in_src;
  logic [VtxW-1:0]           in_dst;
  logic signed [WeightW-1:0] in_wt;
  logic                      src_ok;
  logic                      dst_ok;

  assign in_func = s_axis_tdata[1:0];
  assign in_src  = s_axis_tdata[6:2];
  assign in_dst  = s_axis_tdata[11:7];
  assign in_wt   = s_axis_tdata[27:12];
  assign src_ok  = int'(in_src) < int'(n_eff);
  assign dst_ok  = int'(in_dst) < int'(n_eff);

  // Matrix address of (row, column)
  function automatic logic [AW-1:0] ent_addr(input logic [VtxW-1:0] row,
                                             input logic [CW-1:0]   col);
    return AW'(int'(row) * int'(MAX_VERTICES) + int'(col));
  endfunction

  // Control and result registers
  state_e                    state_q, state_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [CW-1:0]             col_q, col_d;
  logic [CW-1:0]             rcol_q, rcol_d;
  logic                      rd_pend_q, rd_pend_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [CntW-1:0]           cnt_nxt;
  logic                      pend_valid_q, pend_valid_d;
  res_t                      pend_q, pend_d;
  res_t                      res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic [VtxW-1:0]           src_q, src_d;
  logic [VtxW-1:0]           dst_q, dst_d;
  logic signed [WeightW-1:0] wt_q, wt_d;

  // Memory port
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;

  logic out_free;
  logic hit;
  logic stall;

  assign out_free = !out_valid_q || m_axis_tready;
  assign hit      = rd_pend_q && mem_rdata.present && (int'(cnt_q) < int'(MaxResults));
  assign stall    = hit && pend_valid_q && !out_free;

  ams_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  // Sequencer: next state, memory accesses and result loading
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    col_d         = col_q;
    rcol_d        = rcol_q;
    rd_pend_d     = rd_pend_q;
    cnt_d         = cnt_q;
    cnt_nxt       = cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q;
    src_d         = src_q;
    dst_d         = dst_q;
    wt_d          = wt_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = '0;
    s_axis_tready = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        s_axis_tready = out_free;
        if (s_axis_tvalid && out_free) begin
          src_d = in_src;
          dst_d = in_dst;
          wt_d  = in_wt;
          case (in_func)
            FUNC_ADD: begin
              out_valid_d = 1'b1;
              if (src_ok && dst_ok) begin
                mem_we    = 1'b1;
                mem_addr  = ent_addr(in_src, CW'(in_dst));
                mem_wdata = '{present: 1'b1, weight: in_wt};
                res_d     = '{status: 1'b0, found: 1'b1, nb: in_dst, weight: in_wt,
                              last: 1'b1};
                if (!directed_q) begin
                  state_d = S_ADD2;
                end
              end else begin
                res_d = '{status: 1'b1, found: 1'b0, nb: in_dst, weight: '0, last: 1'b1};
              end
            end
            FUNC_LOOKUP: begin
              if (src_ok && dst_ok) begin
                mem_re   = 1'b1;
                mem_addr = ent_addr(in_src, CW'(in_dst));
                state_d  = S_LOOK;
              end else begin
                out_valid_d = 1'b1;
                res_d = '{status: 1'b1, found: 1'b0, nb: in_dst, weight: '0, last: 1'b1};
              end
            end
            FUNC_LIST: begin
              if (src_ok) begin
                col_d        = '0;
                cnt_d        = '0;
                pend_valid_d = 1'b0;
                rd_pend_d    = 1'b0;
                state_d      = S_LIST;
              end else begin
                out_valid_d = 1'b1;
                res_d = '{status: 1'b1, found: 1'b0, nb: '0, weight: '0, last: 1'b1};
              end
            end
            default: begin
              out_valid_d = 1'b1;
              res_d = '{status: 1'b0, found: 1'b0, nb: in_dst, weight: '0, last: 1'b1};
            end
          endcase
        end
      end

      // mirrored entry of an undirected edge
      S_ADD2: begin
        mem_we    = 1'b1;
        mem_addr  = ent_addr(dst_q, CW'(src_q));
        mem_wdata = '{present: 1'b1, weight: wt_q};
        state_d   = S_IDLE;
      end

      S_LOOK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (mem_rdata.present) begin
            res_d = '{status: 1'b0, found: 1'b1, nb: dst_q, weight: mem_rdata.weight,
                      last: 1'b1};
          end else begin
            res_d = '{status: 1'b0, found: 1'b0, nb: dst_q, weight: '0, last: 1'b1};
          end
          state_d = S_IDLE;
        end
      end

      // Row scan: one read a cycle while not stalled; a hit is held until the next hit or
      // the end so that the final one can carry last
      S_LIST: begin
        if (!stall) begin
          if (hit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              res_d       = pend_q;
            end
            pend_d       = '{status: 1'b0, found: 1'b1, nb: VtxW'(rcol_q),
                             weight: mem_rdata.weight, last: 1'b0};
            pend_valid_d = 1'b1;
            cnt_nxt      = cnt_q + CntW'(1);
          end
          cnt_d = cnt_nxt;
          if ((col_q < n_eff) && (int'(cnt_nxt) < int'(MaxResults))) begin
            mem_re    = 1'b1;
            mem_addr  = ent_addr(src_q, col_q);
            rcol_d    = col_q;
            col_d     = col_q + CW'(1);
            rd_pend_d = 1'b1;
          end else begin
            rd_pend_d = 1'b0;
            state_d   = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (pend_valid_q) begin
            res_d      = pend_q;
            res_d.last = 1'b1;
          end else begin
            res_d = '{status: 1'b0, found: 1'b0, nb: '0, weight: '0, last: 1'b1};
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      col_q        <= '0;
      rd_pend_q    <= 1'b0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      col_q        <= col_d;
      rd_pend_q    <= rd_pend_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rcol_q <= rcol_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    wt_q   <= wt_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q.weight, res_q.nb};
  assign m_axis_tuser  = {res_q.found, res_q.status};
  assign m_axis_tlast  = res_q.last;

  // Checks
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("request taken during clearing pass");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LIST || state_q == S_LOOK || state_q == S_FIN) |-> !mem_we)
    else $error("memory written during a read operation");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= int'(MaxResults))
    else $error("listing result count above cap");

  a_pend_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == S_LIST || state_q == S_FIN))
    else $error("held neighbour outside a listing");

  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (state_q == S_IDLE && out_valid_q && res_q.last))
    else $error("listing did not close with a last result");

endmodule

@@ tb/sv/adjacency_matrix_store_test.sv @@
// Self-checking testbench for the adjacency matrix store: random and directed requests.
`timescale 1ns / 1ps

module adjacency_matrix_store_test;
  import ams_pkg::*;

  // Code 3 has no name in the package: the block treats it as a no-op
  localparam logic [FuncW-1:0] FuncNoOp = 2'd3;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = MaxVertices + 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SegItems     = 41;
  localparam int unsigned NumSegs      = 9;

  // Tracks the matrix contents and the results still owed by the block
  class edge_matrix_tracker;
    logic [WeightW-1:0] weight_mem [MaxVertices*MaxVertices];
    bit                 present_mem[MaxVertices*MaxVertices];
    bit                 one_way;
    logic [CfgW-1:0]    vertex_limit;
    res_t               awaited_results[$];
    int                 mismatch_count;
    int                 result_index;

    function new();
      one_way        = 1'b0;
      vertex_limit   = 6'd32;
      mismatch_count = 0;
      result_index   = 0;
      foreach (present_mem[i]) present_mem[i] = 1'b0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
      if (idx == CfgDirected) begin
        one_way = value[0];
      end else if (idx == CfgActive) begin
        vertex_limit = value;
      end
    endfunction

    // Active count, saturated at the matrix side
    function int unsigned span();
      return (vertex_limit > MaxVertices) ? MaxVertices : vertex_limit;
    endfunction

    function void owe(bit status, bit found, logic [VtxW-1:0] nb,
                      logic [WeightW-1:0] weight, bit last);
      res_t r;
      r.status = status;
      r.found  = found;
      r.nb     = nb;
      r.weight = weight;
      r.last   = last;
      awaited_results.push_back(r);
    endfunction

    // Apply one accepted request and queue the results it must cause
    function void note_request(logic [FuncW-1:0] op, logic [VtxW-1:0] src,
                               logic [VtxW-1:0] dst, logic [WeightW-1:0] wt);
      int unsigned n, row, col, idx, hits, emitted, j;
      bit src_ok, dst_ok;
      n      = span();
      row    = 32'(src);
      col    = 32'(dst);
      src_ok = row < n;
      dst_ok = col < n;
      case (op)
        FUNC_ADD: begin
          if (!src_ok || !dst_ok) begin
            owe(1'b1, 1'b0, dst, '0, 1'b1);
          end else begin
            weight_mem[row*MaxVertices + col]  = wt;
            present_mem[row*MaxVertices + col] = 1'b1;
            if (!one_way) begin
              weight_mem[col*MaxVertices + row]  = wt;
              present_mem[col*MaxVertices + row] = 1'b1;
            end
            owe(1'b0, 1'b1, dst, wt, 1'b1);
          end
        end
        FUNC_LOOKUP: begin
          idx = row*MaxVertices + col;
          if (!src_ok || !dst_ok) begin
            owe(1'b1, 1'b0, dst, '0, 1'b1);
          end else if (present_mem[idx]) begin
            owe(1'b0, 1'b1, dst, weight_mem[idx], 1'b1);
          end else begin
            owe(1'b0, 1'b0, dst, '0, 1'b1);
          end
        end
        FUNC_LIST: begin
          if (!src_ok) begin
            owe(1'b1, 1'b0, '0, '0, 1'b1);
          end else begin
            // count first so that the final hit can carry last
            hits = 0;
            for (j = 0; j < n; j++) begin
              if (present_mem[row*MaxVertices + j]) hits++;
            end
            if (hits > MaxResults) hits = MaxResults;
            emitted = 0;
            for (j = 0; j < n && emitted < hits; j++) begin
              if (present_mem[row*MaxVertices + j]) begin
                owe(1'b0, 1'b1, j[VtxW-1:0], weight_mem[row*MaxVertices + j],
                    emitted == hits - 1);
                emitted++;
              end
            end
            if (hits == 0) owe(1'b0, 1'b0, '0, '0, 1'b1);
          end
        end
        default: begin
          owe(1'b0, 1'b0, dst, '0, 1'b1);
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] result %0d: %s", $time, result_index, what);
      mismatch_count++;
    endtask

    task compare_field(string name, logic [WeightW-1:0] got, logic [WeightW-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result nb %0d weight %h", got.nb, got.weight));
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", WeightW'(got.status), WeightW'(want.status));
        compare_field("found", WeightW'(got.found), WeightW'(want.found));
        compare_field("neighbour", WeightW'(got.nb), WeightW'(want.nb));
        compare_field("weight", got.weight, want.weight);
        compare_field("last", WeightW'(got.last), WeightW'(want.last));
      end
      result_index++;
    endtask
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;
  logic               m_axis_tlast;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [CfgW-1:0]    cfg_data_i    = '0;

  edge_matrix_tracker board = new();

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 79;
  bit          hold_request  = 1'b0;
  int unsigned cycle_count   = 0;
  logic [2*VtxW-1:0] recent_pairs[$];

  adjacency_matrix_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("adjacency_matrix_store: mismatch");
    $finish;
  end

  // Result side: check each accepted result, then choose tready for the next cycle
  initial begin
    res_t        got;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.nb     = m_axis_tdata[4:0];
        got.weight = m_axis_tdata[20:5];
        got.status = m_axis_tuser[0];
        got.found  = m_axis_tuser[1];
        got.last   = m_axis_tlast;
        board.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request, with random gaps ahead of it, and wait for acceptance
  task automatic send_request(input logic [FuncW-1:0] op, input logic [VtxW-1:0] src,
                              input logic [VtxW-1:0] dst, input logic [WeightW-1:0] wt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, wt, dst, src, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(op, src, dst, wt);
    if (op == FUNC_ADD) begin
      recent_pairs.push_back({src, dst});
      if (recent_pairs.size() > 16) void'(recent_pairs.pop_front());
    end
  endtask

  // Stop offering, wait for every owed result, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Both registers, one per cycle; the enable stays high across the pair
  task automatic write_config(input bit one_way, input logic [CfgW-1:0] active);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgDirected;
    cfg_data_i <= {{(CfgW-1){1'b0}}, one_way};
    @(posedge clk_i);
    board.write_register(CfgDirected, {{(CfgW-1){1'b0}}, one_way});
    cfg_idx_i  <= CfgActive;
    cfg_data_i <= active;
    @(posedge clk_i);
    board.write_register(CfgActive, active);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly an index inside the active range, sometimes anywhere
  function automatic logic [VtxW-1:0] pick_vertex();
    int unsigned n;
    n = board.span();
    if (n != 0 && $urandom_range(9) != 0) return VtxW'($urandom_range(n - 1));
    return VtxW'($urandom_range(MaxVertices - 1));
  endfunction

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(19))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return WeightW'($urandom_range(16'hffff));
    endcase
  endfunction

  // Populate a whole row, then list it
  task automatic fill_row(input logic [VtxW-1:0] row);
    int unsigned j;
    for (j = 0; j < MaxVertices; j++) send_request(FUNC_ADD, row, j[VtxW-1:0], pick_weight());
    send_request(FUNC_LIST, row, pick_vertex(), pick_weight());
  endtask

  // Random traffic: mostly well-formed operations on live edges, some noise
  task automatic run_random(input int unsigned quota);
    int unsigned issued, pick;
    logic [2*VtxW-1:0] pair;
    issued = 0;
    while (issued < quota) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        fill_row(pick_vertex());
        issued += MaxVertices + 1;
      end else if (pick < 15) begin
        send_request(FuncW'($urandom_range(3)), VtxW'($urandom_range(MaxVertices - 1)),
                     VtxW'($urandom_range(MaxVertices - 1)),
                     WeightW'($urandom_range(16'hffff)));
        issued++;
      end else if (pick < 50) begin
        send_request(FUNC_ADD, pick_vertex(), pick_vertex(), pick_weight());
        issued++;
      end else if (pick < 75) begin
        // lookups lean on edges added recently
        if (recent_pairs.size() != 0 && $urandom_range(9) < 6) begin
          pair = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
          if ($urandom_range(1)) pair = {pair[VtxW-1:0], pair[2*VtxW-1:VtxW]};
          send_request(FUNC_LOOKUP, pair[2*VtxW-1:VtxW], pair[VtxW-1:0], pick_weight());
        end else begin
          send_request(FUNC_LOOKUP, pick_vertex(), pick_vertex(), pick_weight());
        end
        issued++;
      end else if (pick < 95) begin
        send_request(FUNC_LIST, pick_vertex(), pick_vertex(), pick_weight());
        issued++;
      end else begin
        send_request(FuncNoOp, pick_vertex(), pick_vertex(), pick_weight());
        issued++;
      end
    end
  endtask

  // Main sequence
  initial begin
    bit          seg_dir[NumSegs];
    int unsigned seg_act[NumSegs];
    int unsigned seg;
    seg_dir = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    seg_act = '{32, 8, 0, 1, 63, 5, 32, 40, 17};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_config(1'b0, 6'd32);

    // Empty matrix, extreme weights, mirroring, overwrite, self loop, no-op
    send_request(FUNC_LOOKUP, 5'd0, 5'd0, 16'h0000);
    send_request(FUNC_LIST, 5'd0, 5'd0, 16'h0000);
    send_request(FUNC_ADD, 5'd0, 5'd31, 16'h7fff);
    send_request(FUNC_ADD, 5'd31, 5'd31, 16'h8000);
    send_request(FUNC_ADD, 5'd5, 5'd7, 16'h0000);
    send_request(FUNC_ADD, 5'd31, 5'd0, 16'hffff);
    send_request(FUNC_LOOKUP, 5'd0, 5'd31, 16'h0000);
    send_request(FUNC_LOOKUP, 5'd31, 5'd0, 16'h0000);
    send_request(FUNC_LOOKUP, 5'd7, 5'd5, 16'h0000);
    send_request(FUNC_LIST, 5'd31, 5'd0, 16'h0000);
    send_request(FUNC_LIST, 5'd0, 5'd0, 16'h0000);
    send_request(FuncNoOp, 5'd31, 5'd17, 16'h1234);
    drain();

    // Small directed graph: range checks and one-way edges
    write_config(1'b1, 6'd4);
    send_request(FUNC_ADD, 5'd4, 5'd0, 16'h0001);
    send_request(FUNC_ADD, 5'd0, 5'd9, 16'h0002);
    send_request(FUNC_LOOKUP, 5'd9, 5'd0, 16'h0000);
    send_request(FUNC_LOOKUP, 5'd0, 5'd4, 16'h0000);
    send_request(FUNC_LIST, 5'd4, 5'd3, 16'h0000);
    send_request(FUNC_LIST, 5'd0, 5'd0, 16'h0000);
    send_request(FUNC_ADD, 5'd1, 5'd2, 16'h5a5a);
    send_request(FUNC_LOOKUP, 5'd2, 5'd1, 16'h0000);
    send_request(FUNC_LOOKUP, 5'd1, 5'd2, 16'h0000);
    send_request(FUNC_ADD, 5'd3, 5'd3, 16'ha5a5);
    send_request(FUNC_LIST, 5'd1, 5'd0, 16'h0000);
    send_request(FUNC_LIST, 5'd3, 5'd0, 16'h0000);
    drain();

    // Random phases; idling pattern changes every third phase
    for (seg = 0; seg < NumSegs; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_config(seg_dir[seg], seg_act[seg][CfgW-1:0]);
      if (seg == 0) begin
        // long result stall while a full row is written and listed
        hold_request = 1'b1;
        fill_row(5'd13);
      end
      run_random(SegItems);
      drain();
    end

    if (board.mismatch_count == 0 && board.awaited_results.size() == 0) begin
      $display("adjacency_matrix_store: match");
    end else begin
      $display("adjacency_matrix_store: mismatch");
    end
    $finish;
  end

endmodule
